[rtl/motor_speed_smoother_pwm_unit_assert.svh]
// Assertion macros used by the port checker of the speed smoother.
`ifndef MOTOR_SPEED_SMOOTHER_PWM_UNIT_ASSERT_SVH
`define MOTOR_SPEED_SMOOTHER_PWM_UNIT_ASSERT_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define MSP_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("speed smoother check failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define MSP_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("speed smoother check failed");

`endif

[rtl/msp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother package
// Shared types and constants of the speed smoother and PWM unit.
// ----------------------------------------------------------------------------
package msp_pkg;

    localparam int unsigned DIV_W = 48;
    localparam int unsigned DEN_W = 33;
    localparam logic [16:0] ONE_Q = 17'd65536;
    localparam logic [15:0] RECIP3 = 16'd43691;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_QNOISE = 2'd1;
    localparam logic [1:0] REG_RNOISE = 2'd2;
    localparam logic [1:0] REG_REVDIR = 2'd3;

    localparam logic [16:0] RST_PERIOD = 17'd1000;
    localparam logic [31:0] RST_QNOISE = 32'd6554;
    localparam logic [31:0] RST_RNOISE = 32'd65536;

    typedef struct packed {
        logic [16:0] period;
        logic [31:0] qnoise;
        logic [31:0] rnoise;
        logic        revdir;
    } msp_cfg_t;

    typedef struct packed {
        logic load_cmd;
        logic div_k_start;
        logic kal_mul;
        logic kal_commit;
        logic avg_calc;
        logic win_update;
        logic mean_mul;
        logic mean_fin;
        logic out_load;
    } msp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_full;
    } msp_stat_t;

endpackage

[rtl/msp_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Unsigned divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module msp_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [msp_pkg::DIV_W-1:0]   dividend,
    input  logic [msp_pkg::DEN_W-1:0]   divisor,
    output logic [msp_pkg::DIV_W-1:0]   quotient,
    output logic                        done
);

    localparam int unsigned CNT_W = $clog2(msp_pkg::DIV_W);

    logic [msp_pkg::DEN_W:0]   rem_reg, rem_next;
    logic [msp_pkg::DIV_W-1:0] quo_reg, quo_next;
    logic [msp_pkg::DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [msp_pkg::DEN_W:0]   shifted;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg[msp_pkg::DEN_W-1:0], quo_reg[msp_pkg::DIV_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[msp_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[msp_pkg::DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(msp_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[rtl/msp_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother datapath
// Clamp, Kalman update, three-sample average, window sum, mean and output register.
// ----------------------------------------------------------------------------
module msp_datapath
#(
    parameter int unsigned WINDOW = 5
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  msp_pkg::msp_cmd_t   cmd,
    output msp_pkg::msp_stat_t  stat,
    input  msp_pkg::msp_cfg_t   cfg,
    input  logic signed [31:0]  speed_command,
    input  logic                out_ready,
    output logic                out_valid,
    output logic signed [31:0]  filtered_speed,
    output logic [15:0]         compare_value,
    output logic                direction_pin
);

    localparam int unsigned IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int unsigned SUM_W = 18 + $clog2(WINDOW + 1);
    localparam logic [16:0] MEAN_Q0 = 17'(65536 / WINDOW);
    localparam int unsigned MEAN_R0 = 65536 % WINDOW;
    localparam int unsigned REM_W = SUM_W + 6;
    localparam int unsigned REC_SH = REM_W + IDX_W;
    localparam int unsigned REC_W = REM_W + 1;
    localparam longint unsigned REC_M =
        ((64'd1 << REC_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);

    logic signed [34:0]        cmd_reg;
    logic [31:0]               pp_reg;
    logic                      den_zero_reg;
    logic signed [52:0]        prod_e_reg;
    logic [48:0]               prod_p_reg;
    logic signed [31:0]        estimate_reg;
    logic [31:0]               cov_reg;
    logic signed [15:0]        prior0_reg, prior1_reg;
    logic signed [16:0]        avg_reg;
    logic signed [16:0]        win_mem [WINDOW];
    logic [WINDOW-1:0]         win_valid_reg;
    logic signed [16:0]        rd_reg;
    logic                      rd_valid_reg;
    logic [IDX_W-1:0]          idx_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic                      sum_neg_reg;
    logic [31:0]               part_a_reg;
    logic [REM_W-1:0]          rem_t_reg;
    logic [31:0]               mean_mag_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        fs_reg;
    logic [15:0]               cmp_reg;
    logic                      pin_reg;

    logic [16:0]               lim;
    logic signed [34:0]        limq, cmd_ext, cmd_clamped;
    logic [32:0]               pq_sum;
    logic [32:0]               den;
    logic [msp_pkg::DIV_W-1:0] div_quo;
    logic                      div_done;
    logic [16:0]               k;
    logic signed [34:0]        diff;
    logic signed [52:0]        prod_e_next;
    logic [48:0]               prod_p_next;
    logic signed [52:0]        e_adj;
    logic [32:0]               p_hi;
    logic signed [31:0]        est_bias;
    logic signed [15:0]        sample;
    logic signed [17:0]        sum3;
    logic [16:0]               sum3_mag;
    logic [32:0]               third_prod;
    logic [15:0]               third;
    logic signed [16:0]        old_val;
    logic [SUM_W-1:0]          sum_mag;
    logic [SUM_W+16:0]         mean_a;
    logic [REM_W-1:0]          mean_t;
    logic [REM_W+REC_W-1:0]    mean_b_prod;
    logic [31:0]               mean_sum;
    logic [31:0]               mean_mag;
    logic signed [31:0]        fs_val;

    assign lim         = (cfg.period == 17'd0) ? 17'd0 : cfg.period - 17'd1;
    assign limq        = $signed({2'b00, lim, 16'h0000});
    assign cmd_ext     = 35'(speed_command);
    assign cmd_clamped = (cmd_ext > limq) ? limq : ((cmd_ext < -limq) ? -limq : cmd_ext);
    assign pq_sum      = {1'b0, cov_reg} + {1'b0, cfg.qnoise};
    assign den         = {1'b0, pp_reg} + {1'b0, cfg.rnoise};

    assign k           = den_zero_reg ? 17'd0 : div_quo[16:0];
    assign diff        = cmd_reg - 35'(estimate_reg);
    assign prod_e_next = $signed({1'b0, k}) * diff;
    assign prod_p_next = (msp_pkg::ONE_Q - k) * pp_reg;
    assign e_adj       = prod_e_reg[52] ? ((prod_e_reg + 53'sd65535) >>> 16)
                                        : (prod_e_reg >>> 16);
    assign p_hi        = prod_p_reg[48:16];

    assign est_bias    = estimate_reg[31] ? estimate_reg + 32'sd65535 : estimate_reg;
    assign sample      = est_bias[31:16];
    assign sum3        = 18'(prior0_reg) + 18'(prior1_reg) + 18'(sample);
    assign sum3_mag    = sum3[17] ? 17'(-sum3) : sum3[16:0];
    assign third_prod  = sum3_mag * msp_pkg::RECIP3;
    assign third       = third_prod[32:17];

    assign old_val     = rd_valid_reg ? rd_reg : 17'sd0;
    assign sum_mag     = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mean_a      = sum_mag * MEAN_Q0;
    assign mean_t      = REM_W'(sum_mag) * REM_W'(MEAN_R0);
    assign mean_b_prod = rem_t_reg * REC_W'(REC_M);
    assign mean_sum    = part_a_reg + 32'(mean_b_prod[REM_W+REC_W-1:REC_SH]);
    assign mean_mag    = mean_mag_reg;
    assign fs_val      = sum_neg_reg ? -$signed(mean_mag) : $signed(mean_mag);

    msp_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_k_start),
        .dividend ({pp_reg, 16'h0000}),
        .divisor  (den),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            estimate_reg  <= '0;
            cov_reg       <= 32'd65536;
            prior0_reg    <= '0;
            prior1_reg    <= '0;
            win_valid_reg <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.kal_commit)
            begin
                estimate_reg <= estimate_reg + e_adj[31:0];
                cov_reg      <= p_hi[32] ? 32'hFFFF_FFFF : p_hi[31:0];
            end
            if (cmd.avg_calc)
            begin
                prior0_reg <= prior1_reg;
                prior1_reg <= sample;
            end
            if (cmd.win_update)
            begin
                win_valid_reg[idx_reg] <= 1'b1;
                sum_reg <= sum_reg - SUM_W'(old_val) + SUM_W'(avg_reg);
                idx_reg <= (idx_reg == IDX_W'(WINDOW - 1)) ? '0 : idx_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_cmd)
        begin
            cmd_reg <= cmd_clamped;
            pp_reg  <= pq_sum[32] ? 32'hFFFF_FFFF : pq_sum[31:0];
        end
        if (cmd.div_k_start)
        begin
            den_zero_reg <= (den == 33'd0);
        end
        if (cmd.kal_mul)
        begin
            prod_e_reg <= prod_e_next;
            prod_p_reg <= prod_p_next;
        end
        if (cmd.avg_calc)
        begin
            avg_reg      <= sum3[17] ? -$signed({1'b0, third}) : $signed({1'b0, third});
            rd_reg       <= win_mem[idx_reg];
            rd_valid_reg <= win_valid_reg[idx_reg];
        end
        if (cmd.win_update)
        begin
            win_mem[idx_reg] <= avg_reg;
        end
        if (cmd.mean_mul)
        begin
            sum_neg_reg <= sum_reg[SUM_W-1];
            part_a_reg  <= mean_a[31:0];
            rem_t_reg   <= mean_t;
        end
        if (cmd.mean_fin)
        begin
            mean_mag_reg <= mean_sum;
        end
        if (cmd.out_load)
        begin
            fs_reg  <= fs_val;
            cmp_reg <= mean_mag[31:16];
            pin_reg <= cfg.revdir ? (fs_val[31] || fs_val == 32'sd0) : !fs_val[31];
        end
    end

    assign stat.div_done  = div_done;
    assign stat.out_full  = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign filtered_speed = fs_reg;
    assign compare_value  = cmp_reg;
    assign direction_pin  = pin_reg;

endmodule

[rtl/msp_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother controller
// Sequences one command beat through the datapath steps.
// ----------------------------------------------------------------------------
module msp_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output msp_pkg::msp_cmd_t   cmd,
    input  msp_pkg::msp_stat_t  stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_KSTART = 4'd1;
    localparam logic [3:0] S_KWAIT  = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_COMMIT = 4'd4;
    localparam logic [3:0] S_AVG    = 4'd5;
    localparam logic [3:0] S_WIN    = 4'd6;
    localparam logic [3:0] S_MMUL   = 4'd7;
    localparam logic [3:0] S_MFIN   = 4'd8;
    localparam logic [3:0] S_OUT    = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_cmd = 1'b1;
                    state_next   = S_KSTART;
                end
            end
            S_KSTART:
            begin
                cmd.div_k_start = 1'b1;
                state_next      = S_KWAIT;
            end
            S_KWAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.kal_mul = 1'b1;
                state_next  = S_COMMIT;
            end
            S_COMMIT:
            begin
                cmd.kal_commit = 1'b1;
                state_next     = S_AVG;
            end
            S_AVG:
            begin
                cmd.avg_calc = 1'b1;
                state_next   = S_WIN;
            end
            S_WIN:
            begin
                cmd.win_update = 1'b1;
                state_next     = S_MMUL;
            end
            S_MMUL:
            begin
                cmd.mean_mul = 1'b1;
                state_next   = S_MFIN;
            end
            S_MFIN:
            begin
                cmd.mean_fin = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/motor_speed_smoother_pwm_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Motor speed smoother and PWM unit
// Kalman-filtered, averaged speed command with PWM compare and direction.
// ----------------------------------------------------------------------------
// An accepted command beat runs through the controller steps to the result beat.
// One 48-step pass of the restoring gain divider is the longest of them,
// and nine further controller steps around it do the rest.
// One command is in flight at a time, so the next beat is taken only after the result
// beat is loaded, and that waits while an earlier result beat waits for the receiver.
// Reset restores the register defaults, the filter state and clears the window.
module motor_speed_smoother_pwm_unit
#(
    parameter int unsigned WINDOW = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] speed_command,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] filtered_speed,
    output logic [15:0]        compare_value,
    output logic               direction_pin
);

    msp_pkg::msp_cfg_t  cfg_reg;
    msp_pkg::msp_cmd_t  cmd;
    msp_pkg::msp_stat_t stat;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period <= msp_pkg::RST_PERIOD;
            cfg_reg.qnoise <= msp_pkg::RST_QNOISE;
            cfg_reg.rnoise <= msp_pkg::RST_RNOISE;
            cfg_reg.revdir <= 1'b0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                msp_pkg::REG_PERIOD: cfg_reg.period <= pwdata[16:0];
                msp_pkg::REG_QNOISE: cfg_reg.qnoise <= pwdata;
                msp_pkg::REG_RNOISE: cfg_reg.rnoise <= pwdata;
                msp_pkg::REG_REVDIR: cfg_reg.revdir <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            msp_pkg::REG_PERIOD: prdata = {15'd0, cfg_reg.period};
            msp_pkg::REG_QNOISE: prdata = cfg_reg.qnoise;
            msp_pkg::REG_RNOISE: prdata = cfg_reg.rnoise;
            msp_pkg::REG_REVDIR: prdata = {31'd0, cfg_reg.revdir};
            default:             prdata = '0;
        endcase
    end

    msp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    msp_datapath #(.WINDOW(WINDOW)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg            (cfg_reg),
        .speed_command  (speed_command),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .filtered_speed (filtered_speed),
        .compare_value  (compare_value),
        .direction_pin  (direction_pin)
    );

endmodule

[rtl/msp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother port checker
// Port-level checks of the speed smoother, bound to the top level.
// ----------------------------------------------------------------------------
`include "motor_speed_smoother_pwm_unit_assert.svh"

module msp_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               pready,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] filtered_speed,
    input logic [15:0]        compare_value
);

    logic [31:0] neg_speed;

    assign neg_speed = -filtered_speed;

    `MSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(filtered_speed))
    `MSP_ASSERT_NOW(a_cmp_mag, clk, rst_n, out_valid, compare_value == (filtered_speed[31] ? neg_speed[31:16] : filtered_speed[31:16]))
    `MSP_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `MSP_ASSERT_NEXT(a_no_instant_result, clk, rst_n, out_valid && out_ready, !out_valid)
    `MSP_ASSERT_NOW(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind motor_speed_smoother_pwm_unit msp_checker u_msp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_speed (filtered_speed),
    .compare_value  (compare_value)
);

[dv/msp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother checker
// Watches the register port and both beat channels of the speed smoother,
// predicts each result from its own copy of the filter state and compares
// the result beats field by field in order.
// ----------------------------------------------------------------------------
module msp_scoreboard
#(
    parameter int unsigned WINDOW = 5
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [31:0] speed_command,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] filtered_speed,
    input  logic [15:0]        compare_value,
    input  logic               direction_pin,
    output int                 errors,
    output int                 pending
);

    typedef struct {
        logic signed [31:0] speed;
        logic [15:0]        compare;
        logic               dir;
    } speed_result_t;

    msp_pkg::msp_cfg_t      cfg;
    logic signed [31:0]     est;
    logic [31:0]            cov;
    logic signed [31:0]     prior [2];
    logic signed [31:0]     win [WINDOW];
    int unsigned            win_idx;
    logic signed [31:0]     win_sum;
    speed_result_t          expected_q [$];

    assign pending = expected_q.size();

    function automatic longint unsigned sat32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function automatic speed_result_t smooth_command(logic signed [31:0] raw);
        speed_result_t       r;
        longint              cmd;
        longint              limq;
        longint unsigned     pp;
        longint unsigned     den;
        longint unsigned     k;
        longint              diff;
        longint              sample;
        longint              avg;
        longint              mean;
        logic signed [31:0]  old;
        cmd  = longint'(raw);
        limq = (cfg.period >= 1) ? longint'(cfg.period - 1) * 65536 : 0;
        if (cmd > limq)
        begin
            cmd = limq;
        end
        if (cmd < -limq)
        begin
            cmd = -limq;
        end
        pp   = sat32(longint'(cov) + longint'(cfg.qnoise));
        den  = pp + longint'(cfg.rnoise);
        k    = (den == 0) ? 0 : (pp << 16) / den;
        diff = cmd - longint'(est);
        est  = 32'(longint'(est) + (longint'(k) * diff) / 65536);
        cov  = 32'(sat32(((65536 - k) * pp) >> 16));
        sample = longint'(est) / 65536;
        avg    = (longint'(prior[0]) + longint'(prior[1]) + sample) / 3;
        prior[0] = prior[1];
        prior[1] = 32'(sample);
        if (win_idx >= WINDOW)
        begin
            win_idx = 0;
        end
        old          = win[win_idx];
        win[win_idx] = 32'(avg);
        win_sum      = win_sum - old + 32'(avg);
        win_idx      = (win_idx + 1) % WINDOW;
        mean      = (longint'(win_sum) * 65536) / longint'(WINDOW);
        r.speed   = 32'(mean);
        r.compare = 16'(((mean < 0) ? -mean : mean) / 65536);
        r.dir     = cfg.revdir ? (r.speed <= 0) : (r.speed >= 0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        speed_result_t e;
        if (!rst_n)
        begin
            cfg      = '{period: msp_pkg::RST_PERIOD, qnoise: msp_pkg::RST_QNOISE,
                         rnoise: msp_pkg::RST_RNOISE, revdir: 1'b0};
            est      = '0;
            cov      = 32'd65536;
            prior    = '{default: '0};
            win      = '{default: '0};
            win_idx  = 0;
            win_sum  = '0;
            errors   = 0;
            expected_q.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    msp_pkg::REG_PERIOD: cfg.period = pwdata[16:0];
                    msp_pkg::REG_QNOISE: cfg.qnoise = pwdata;
                    msp_pkg::REG_RNOISE: cfg.rnoise = pwdata;
                    msp_pkg::REG_REVDIR: cfg.revdir = pwdata[0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result beat with no command pending: speed %0d", filtered_speed);
                    errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if (filtered_speed !== e.speed)
                    begin
                        $error("filtered_speed expected %0d actual %0d", e.speed,
                               filtered_speed);
                        errors++;
                    end
                    if (compare_value !== e.compare)
                    begin
                        $error("compare_value expected %0d actual %0d", e.compare,
                               compare_value);
                        errors++;
                    end
                    if (direction_pin !== e.dir)
                    begin
                        $error("direction_pin expected %0b actual %0b", e.dir,
                               direction_pin);
                        errors++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(smooth_command(speed_command));
            end
        end
    end

endmodule

[dv/motor_speed_smoother_pwm_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Speed smoother testbench
// Drives directed and random speed commands through several register
// settings and idle patterns; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module motor_speed_smoother_pwm_unit_tb;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] speed_command;
    logic               out_valid;
    logic               out_ready;
    logic signed [31:0] filtered_speed;
    logic [15:0]        compare_value;
    logic               direction_pin;
    int                 errors;
    int                 pending;
    int                 send_idle;
    int                 recv_idle;
    int                 hold_cycles;
    longint             cycle_count;
    logic [16:0]        period_now;

    motor_speed_smoother_pwm_unit DUT (.*);

    msp_scoreboard CHK (.*);

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #1 clk = ~clk;
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 2000000)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_command(logic signed [31:0] cmd);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle)
        begin
            gap++;
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        speed_command <= cmd;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (110) @(posedge clk);
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin send_idle = 0;  recv_idle = 0;  end
            1: begin send_idle = 55; recv_idle = 0;  end
            2: begin send_idle = 0;  recv_idle = 55; end
            default: begin send_idle = 16; recv_idle = 16; end
        endcase
    endtask

    function automatic logic signed [31:0] random_command();
        int unsigned sel;
        logic [31:0] lim;
        sel = $urandom_range(9);
        lim = (period_now > 1) ? 32'(period_now - 1) << 16 : 32'd0;
        if (sel < 2 || lim == 0)
        begin
            return $urandom();
        end
        else if (sel == 2)
        begin
            return $urandom_range(1) ? $signed(lim) : -$signed(lim);
        end
        return $signed(32'($urandom_range(lim))) * ($urandom_range(1) ? 1 : -1);
    endfunction

    initial
    begin
        logic signed [31:0] directed [$];
        logic [16:0]        periods [5];
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        speed_command = '0;
        hold_cycles   = 0;
        period_now    = msp_pkg::RST_PERIOD;
        set_idle(0);
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        directed = '{32'sh7FFF_FFFF, 32'sh8000_0000, 0, -1, 1, 32'sh03E7_0000,
                     -32'sh03E7_0000, 32'sh03E8_0000, 32'sh0001_0000, -32'sh0001_0000,
                     32'sh5555_5555, 32'shAAAA_AAAA};
        foreach (directed[i])
        begin
            send_command(directed[i]);
        end
        drain();

        write_reg(msp_pkg::REG_PERIOD, 32'd0);
        write_reg(msp_pkg::REG_REVDIR, 32'd1);
        send_command(32'sh7FFF_FFFF);
        send_command(-32'sh0100_0000);
        drain();
        write_reg(msp_pkg::REG_PERIOD, 32'd1);
        write_reg(msp_pkg::REG_QNOISE, 32'd0);
        write_reg(msp_pkg::REG_RNOISE, 32'd0);
        send_command(32'sh0000_8000);
        drain();
        write_reg(msp_pkg::REG_PERIOD, 32'h1_0000);
        for (int i = 0; i < 4; i++)
        begin
            send_command(i[0] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);
        end
        drain();
        write_reg(msp_pkg::REG_QNOISE, 32'hFFFF_FFFF);
        write_reg(msp_pkg::REG_RNOISE, 32'hFFFF_FFFF);
        write_reg(msp_pkg::REG_REVDIR, 32'd0);
        send_command(32'sh7FFF_FFFF);
        send_command(32'sh8000_0000);
        drain();

        periods = '{17'd2, 17'h1_0000, 17'd1000, 17'd1, 17'd300};
        for (int ph = 0; ph < 8; ph++)
        begin
            period_now = (ph < 5) ? periods[ph] : 17'($urandom_range(65536, 2));
            write_reg(msp_pkg::REG_PERIOD, 32'(period_now));
            write_reg(msp_pkg::REG_QNOISE, (ph == 2) ? 32'd0 : (ph == 3) ? 32'hFFFF_FFFF
                                                   : $urandom_range(200000));
            write_reg(msp_pkg::REG_RNOISE, (ph == 4) ? 32'd1 : (ph == 5) ? 32'hFFFF_FFFF
                                                   : $urandom_range(300000, 1));
            write_reg(msp_pkg::REG_REVDIR, 32'(ph % 2));
            set_idle(ph % 4);
            for (int n = 0; n < 66; n++)
            begin
                if (ph == 1 && n == 20)
                begin
                    hold_cycles = 600;
                end
                send_command(random_command());
            end
            drain();
        end

        set_idle(0);
        drain();
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

[motor_speed_smoother_pwm_unit.f]
+incdir+rtl
rtl/msp_pkg.sv
rtl/msp_div.sv
rtl/msp_datapath.sv
rtl/msp_ctrl.sv
rtl/motor_speed_smoother_pwm_unit.sv
rtl/msp_checker.sv
dv/msp_checker.sv
dv/motor_speed_smoother_pwm_unit_tb.sv
